// ===== sv/rmms_pkg.sv =====
// Shared types and constants for the range minimum/maximum segment tree.
// Used by rmms_ctrl, rmms_datapath and range_min_max_segment_tree.
// No dependencies.
package rmms_pkg;

	localparam int LEAVES   = 1024;
	localparam int NODE_CNT = 2 * LEAVES;
	localparam int NODE_W   = $clog2(NODE_CNT);
	localparam int PTR_W    = NODE_W + 1;
	localparam int POS_W    = 11;
	localparam int VAL_W    = 31;

	localparam logic signed [VAL_W-1:0] SENT_HIGH = VAL_W'(32'sh3f3f3f3f);
	localparam logic signed [VAL_W-1:0] SENT_LOW  = VAL_W'(-32'sh3f3f3f3f);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_W_READ,
		S_W_MERGE,
		S_Q_LEFT,
		S_Q_RIGHT,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_LEAF,
		OP_WREAD,
		OP_WMERGE,
		OP_QINIT,
		OP_QBAD,
		OP_QLEFT,
		OP_QRIGHT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cmd_query;
		logic write_ok;
		logic query_bad;
		logic k_is_root;
		logic q_done;
		logic clear_last;
	} dp_status_t;

endpackage

// ===== sv/rmms_ctrl.sv =====
// Sequencer for the segment tree: clearing pass, write walk and query walk.
// Drives the datapath through rmms_pkg::ctrl_cmd_t; depends on rmms_pkg.
module rmms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rmms_pkg::dp_status_t st,
	output rmms_pkg::ctrl_cmd_t  cmd
);
	import rmms_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clear_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.cmd_query == CMD_WRITE) begin
					if (st.write_ok) begin
						cmd.op  = OP_LEAF;
						state_d = S_W_READ;
					end else begin
						state_d = S_IDLE;
					end
				end else if (st.query_bad) begin
					cmd.op  = OP_QBAD;
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_QINIT;
					state_d = S_Q_LEFT;
				end
			end
			S_W_READ: begin
				if (st.k_is_root) begin
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_WREAD;
					state_d = S_W_MERGE;
				end
			end
			S_W_MERGE: begin
				cmd.op  = OP_WMERGE;
				state_d = S_W_READ;
			end
			S_Q_LEFT: begin
				if (st.q_done) begin
					state_d = S_FINISH;
				end else begin
					cmd.op  = OP_QLEFT;
					state_d = S_Q_RIGHT;
				end
			end
			S_Q_RIGHT: begin
				cmd.op  = OP_QRIGHT;
				state_d = S_Q_LEFT;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	// A pending result is never overwritten before the receiver takes it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while stalled");

	// The store leaves the clearing pass only after its last entry.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) == S_CLEAR) |-> $past(st.clear_last))
		else $error("clearing pass ended early");

	// Each merge uses sibling data fetched in the cycle before.
	a_merge_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_MERGE |-> $past(state_q) == S_W_READ)
		else $error("merge without sibling read");

endmodule

// ===== sv/rmms_datapath.sv =====
// Datapath of the segment tree: node memory, item and config registers,
// write and query walkers, result register. Depends on rmms_pkg.
module rmms_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rmms_pkg::ctrl_cmd_t                     cmd,
	output rmms_pkg::dp_status_t                    st,
	input  logic                                    cfg_we,
	input  logic [rmms_pkg::POS_W-1:0]              cfg_data,
	input  logic                                    command,
	input  logic [rmms_pkg::POS_W-1:0]              left_position,
	input  logic [rmms_pkg::POS_W-1:0]              right_position,
	input  logic signed [rmms_pkg::VAL_W-1:0]       new_value,
	output logic signed [rmms_pkg::VAL_W-1:0]       range_maximum,
	output logic signed [rmms_pkg::VAL_W-1:0]       range_minimum,
	output logic                                    empty_range,
	output logic                                    bad_range
);
	import rmms_pkg::*;

	// Each word holds the node maximum in the upper half and the minimum below.
	logic [2*VAL_W-1:0] node_mem [NODE_CNT];
	logic [2*VAL_W-1:0] rdata_q;

	logic                    cmd_q;
	logic [POS_W-1:0]        left_q, right_q, leaves_q;
	logic signed [VAL_W-1:0] value_q;
	logic [NODE_W-1:0]       k_q, clr_q;
	logic signed [VAL_W-1:0] cur_min_q, cur_max_q, lo_q, hi_q;
	logic [PTR_W-1:0]        a_q, b_q;
	logic                    bad_q, abs_q;
	logic signed [VAL_W-1:0] out_max_q, out_min_q;
	logic                    out_empty_q, out_bad_q;

	logic                    we, re;
	logic [NODE_W-1:0]       waddr, raddr;
	logic [2*VAL_W-1:0]      wdata;
	logic [POS_W-1:0]        used;
	logic signed [VAL_W-1:0] sat_value, rd_min, rd_max, par_min, par_max;
	logic [PTR_W-1:0]        leaf_ptr, b_dec;

	always_comb begin
		used = (leaves_q > POS_W'(LEAVES)) ? POS_W'(LEAVES) : leaves_q;
		if (value_q > SENT_HIGH)
			sat_value = SENT_HIGH;
		else if (value_q < SENT_LOW)
			sat_value = SENT_LOW;
		else
			sat_value = value_q;
		rd_max   = $signed(rdata_q[2*VAL_W-1:VAL_W]);
		rd_min   = $signed(rdata_q[VAL_W-1:0]);
		par_min  = (rd_min < cur_min_q) ? rd_min : cur_min_q;
		par_max  = (rd_max > cur_max_q) ? rd_max : cur_max_q;
		leaf_ptr = PTR_W'(LEAVES) + PTR_W'(left_q) - PTR_W'(1);
		b_dec    = b_q - PTR_W'(1);
	end

	always_comb begin
		st.cmd_query  = cmd_q;
		st.write_ok   = (left_q != '0) && (left_q <= used);
		st.query_bad  = (left_q == '0) || (left_q > right_q) || (right_q > used);
		st.k_is_root  = (k_q == NODE_W'(1));
		st.q_done     = !(a_q < b_q);
		st.clear_last = (clr_q == '1);
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = leaf_ptr[NODE_W-1:0];
		raddr = a_q[NODE_W-1:0];
		wdata = {sat_value, sat_value};
		unique case (cmd.op)
			OP_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = {SENT_LOW, SENT_HIGH};
			end
			OP_LEAF: begin
				we = 1'b1;
			end
			OP_WREAD: begin
				re    = 1'b1;
				raddr = k_q ^ NODE_W'(1);
			end
			OP_WMERGE: begin
				we    = 1'b1;
				waddr = k_q >> 1;
				wdata = {par_max, par_min};
			end
			OP_QLEFT: begin
				re = a_q[0];
			end
			OP_QRIGHT: begin
				re    = b_q[0];
				raddr = b_dec[NODE_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			node_mem[waddr] <= wdata;
		if (re)
			rdata_q <= node_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaves_q <= POS_W'(LEAVES);
			clr_q    <= '0;
			abs_q    <= 1'b0;
		end else begin
			if (cfg_we)
				leaves_q <= cfg_data;
			if (cmd.op == OP_CLEAR)
				clr_q <= clr_q + NODE_W'(1);
			abs_q <= ((cmd.op == OP_QLEFT) && a_q[0]) || ((cmd.op == OP_QRIGHT) && b_q[0]);
		end
	end

	always_ff @(posedge clk) begin
		// A node fetched by the query walk is folded in the cycle after the fetch.
		if (abs_q) begin
			if (rd_min < lo_q)
				lo_q <= rd_min;
			if (rd_max > hi_q)
				hi_q <= rd_max;
		end
		case (cmd.op)
			OP_LOAD: begin
				cmd_q   <= command;
				left_q  <= left_position;
				right_q <= right_position;
				value_q <= new_value;
			end
			OP_LEAF: begin
				k_q       <= leaf_ptr[NODE_W-1:0];
				cur_min_q <= sat_value;
				cur_max_q <= sat_value;
			end
			OP_WMERGE: begin
				k_q       <= k_q >> 1;
				cur_min_q <= par_min;
				cur_max_q <= par_max;
			end
			OP_QINIT: begin
				a_q   <= leaf_ptr;
				b_q   <= PTR_W'(LEAVES) + PTR_W'(right_q);
				lo_q  <= SENT_HIGH;
				hi_q  <= SENT_LOW;
				bad_q <= 1'b0;
			end
			OP_QBAD: begin
				lo_q  <= SENT_HIGH;
				hi_q  <= SENT_LOW;
				bad_q <= 1'b1;
			end
			OP_QLEFT: begin
				if (a_q[0])
					a_q <= a_q + PTR_W'(1);
			end
			OP_QRIGHT: begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_max_q   <= hi_q;
			out_min_q   <= lo_q;
			out_empty_q <= !bad_q && (hi_q < lo_q);
			out_bad_q   <= bad_q;
		end
	end

	assign range_maximum = out_max_q;
	assign range_minimum = out_min_q;
	assign empty_range   = out_empty_q;
	assign bad_range     = out_bad_q;

	// A fold only follows a fetch issued by the query walk.
	a_abs_source: assert property (@(posedge clk) disable iff (!arst_n)
		abs_q |-> ($past(cmd.op) == OP_QLEFT || $past(cmd.op) == OP_QRIGHT))
		else $error("fold without query fetch");

endmodule

// ===== sv/range_min_max_segment_tree.sv =====
// Top level of the range minimum/maximum segment tree.
// Instantiates rmms_ctrl and rmms_datapath; depends on rmms_pkg.
//
// Input channel (in_valid/in_ready) carries one transaction per command:
// a write of new_value to left_position, or a query over the inclusive
// range left_position..right_position. Writes give no result; each query
// gives one result transaction on the output channel (out_valid/out_ready).
// The config channel (cfg_valid/cfg_ready, always ready) sets the number of
// positions in use; write it only while the block is idle.
// One item is worked at a time. A write walks from the leaf to the root,
// reading one sibling and writing one parent per level through the single
// read and single write port of the node memory. A query climbs until the
// two range bounds meet (at most 11 levels) and may need two reads a level.
// After reset all 2048 entries of the node memory are swept to the empty
// sentinels, one entry a cycle; in_ready stays low until the sweep ends.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result then waits until the first
// one has been taken.
module range_min_max_segment_tree (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rmms_pkg::POS_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic [rmms_pkg::POS_W-1:0]        left_position,
	input  logic [rmms_pkg::POS_W-1:0]        right_position,
	input  logic signed [rmms_pkg::VAL_W-1:0] new_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rmms_pkg::VAL_W-1:0] range_maximum,
	output logic signed [rmms_pkg::VAL_W-1:0] range_minimum,
	output logic                              empty_range,
	output logic                              bad_range
);
	import rmms_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	rmms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rmms_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.command        (command),
		.left_position  (left_position),
		.right_position (right_position),
		.new_value      (new_value),
		.range_maximum  (range_maximum),
		.range_minimum  (range_minimum),
		.empty_range    (empty_range),
		.bad_range      (bad_range)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for range_min_max_segment_tree: a scoreboard class keeps its
// own min/max segment tree and the queue of query answers still due.
// Depends on rmms_pkg and the RTL of range_min_max_segment_tree.
module testbench;
	import rmms_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HIGH_MARK     = int'(SENT_HIGH);
	localparam int LOW_MARK      = int'(SENT_LOW);
	localparam int POS_MAX       = (1 << POS_W) - 1;

	typedef struct packed {
		logic signed [VAL_W-1:0] maximum;
		logic signed [VAL_W-1:0] minimum;
		logic                    is_empty;
		logic                    is_bad;
	} range_result_t;

	class minmax_tracker;
		int            node_lo[NODE_CNT];
		int            node_hi[NODE_CNT];
		int unsigned   span;
		range_result_t answers_due[$];
		int            mismatches;

		function new();
			for (int k = 0; k < NODE_CNT; k++) begin
				node_lo[k] = HIGH_MARK;
				node_hi[k] = LOW_MARK;
			end
			span = LEAVES;
			mismatches = 0;
		endfunction

		function void set_span(logic [POS_W-1:0] setting);
			span = (setting > LEAVES) ? LEAVES : setting;
		endfunction

		function int outstanding();
			return answers_due.size();
		endfunction

		function void take_node(int unsigned k, inout int lo, inout int hi);
			if (node_lo[k] < lo)
				lo = node_lo[k];
			if (node_hi[k] > hi)
				hi = node_hi[k];
		endfunction

		function void record_command(logic cmd, logic [POS_W-1:0] l, logic [POS_W-1:0] r,
				logic signed [VAL_W-1:0] v);
			int            val;
			int            lo;
			int            hi;
			int unsigned   a;
			int unsigned   b;
			range_result_t res;
			if (cmd == CMD_WRITE) begin
				if (l == 0 || l > span)
					return;
				val = v;
				if (val > HIGH_MARK)
					val = HIGH_MARK;
				if (val < LOW_MARK)
					val = LOW_MARK;
				a = LEAVES + l - 1;
				node_lo[a] = val;
				node_hi[a] = val;
				for (a = a >> 1; a >= 1; a = a >> 1) begin
					node_lo[a] = (node_lo[2*a] < node_lo[2*a+1]) ? node_lo[2*a] : node_lo[2*a+1];
					node_hi[a] = (node_hi[2*a] > node_hi[2*a+1]) ? node_hi[2*a] : node_hi[2*a+1];
				end
				return;
			end
			if (l == 0 || l > r || r > span) begin
				res.maximum  = SENT_LOW;
				res.minimum  = SENT_HIGH;
				res.is_empty = 1'b0;
				res.is_bad   = 1'b1;
			end else begin
				lo = HIGH_MARK;
				hi = LOW_MARK;
				// Bottom-up walk over the half-open leaf interval [a, b).
				a = LEAVES + l - 1;
				b = LEAVES + r;
				while (a < b) begin
					if (a % 2 == 1) begin
						take_node(a, lo, hi);
						a++;
					end
					if (b % 2 == 1) begin
						b--;
						take_node(b, lo, hi);
					end
					a = a >> 1;
					b = b >> 1;
				end
				res.maximum  = VAL_W'(hi);
				res.minimum  = VAL_W'(lo);
				res.is_empty = (hi < lo);
				res.is_bad   = 1'b0;
			end
			answers_due.push_back(res);
		endfunction

		function void compare_field(string name, int want, int got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_answer(range_result_t got);
			range_result_t want;
			if (answers_due.size() == 0) begin
				$error("result with no query outstanding: max %0d min %0d",
					got.maximum, got.minimum);
				mismatches++;
				return;
			end
			want = answers_due.pop_front();
			compare_field("range_maximum", int'(want.maximum), int'(got.maximum));
			compare_field("range_minimum", int'(want.minimum), int'(got.minimum));
			compare_field("empty_range", int'(want.is_empty), int'(got.is_empty));
			compare_field("bad_range", int'(want.is_bad), int'(got.is_bad));
		endfunction
	endclass

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    cfg_valid      = 1'b0;
	logic                    cfg_ready;
	logic [POS_W-1:0]        cfg_data       = '0;
	logic                    in_valid       = 1'b0;
	logic                    in_ready;
	logic                    command        = CMD_WRITE;
	logic [POS_W-1:0]        left_position  = '0;
	logic [POS_W-1:0]        right_position = '0;
	logic signed [VAL_W-1:0] new_value      = '0;
	logic                    out_valid;
	logic                    out_ready      = 1'b0;
	logic signed [VAL_W-1:0] range_maximum;
	logic signed [VAL_W-1:0] range_minimum;
	logic                    empty_range;
	logic                    bad_range;

	logic        rx_hold        = 1'b0;
	logic        pressure_armed = 1'b0;
	int unsigned send_idle_pct  = 0;
	int unsigned rx_stall_pct   = 0;
	int          cycle_count    = 0;

	minmax_tracker tracker = new();

	range_min_max_segment_tree dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.left_position  (left_position),
		.right_position (right_position),
		.new_value      (new_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.range_maximum  (range_maximum),
		.range_minimum  (range_minimum),
		.empty_range    (empty_range),
		.bad_range      (bad_range)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles", CYCLE_LIMIT);
			$display("FAIL range_min_max_segment_tree");
			$finish;
		end
	end

	// Every transaction is observed at the edge that accepts it.
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			tracker.set_span(cfg_data);
		if (in_valid && in_ready)
			tracker.record_command(command, left_position, right_position, new_value);
		if (out_valid && out_ready)
			tracker.check_answer('{range_maximum, range_minimum, empty_range, bad_range});
	end

	always @(posedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Long receiver hold-off so that the output register fills and the input backs up.
	initial begin
		wait (pressure_armed);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_item(input logic cmd, input logic [POS_W-1:0] l,
			input logic [POS_W-1:0] r, input logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		left_position  <= l;
		right_position <= r;
		new_value      <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drops the input, waits for every answer, then lets a trailing write finish.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_span(input logic [POS_W-1:0] setting);
		cfg_valid <= 1'b1;
		cfg_data  <= setting;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_command(input int unsigned span);
		int unsigned             shape;
		int unsigned             vpick;
		int unsigned             hot;
		int unsigned             reach;
		logic                    cmd;
		logic [POS_W-1:0]        l;
		logic [POS_W-1:0]        r;
		logic signed [VAL_W-1:0] v;
		shape = $urandom_range(99);
		cmd   = ($urandom_range(99) < 45) ? CMD_WRITE : CMD_QUERY;
		// Half of the well-formed traffic stays in a small window so that it collides.
		hot   = ($urandom_range(1) == 0 && span > 32) ? 32 : span;
		reach = $urandom_range(6);
		l     = POS_W'($urandom_range(POS_MAX));
		r     = POS_W'($urandom_range(POS_MAX));
		if (span != 0 && shape >= 6) begin
			if (shape < 9) begin
				l = '0;
				r = POS_W'($urandom_range(span));
			end else if (shape < 12) begin
				l = POS_W'($urandom_range(span, 1));
				r = POS_W'($urandom_range(l - 1));
			end else if (shape < 15) begin
				l = POS_W'($urandom_range(span, 1));
				r = POS_W'($urandom_range(POS_MAX, span + 1));
			end else if (shape < 55) begin
				l = POS_W'($urandom_range(hot, 1));
				r = (l + reach > span) ? POS_W'(span) : POS_W'(l + reach);
			end else begin
				l = POS_W'($urandom_range(hot, 1));
				r = POS_W'($urandom_range(span, l));
			end
		end
		vpick = $urandom_range(9);
		if (vpick < 5)
			v = VAL_W'($urandom);
		else if (vpick < 8)
			v = VAL_W'(int'($urandom_range(40)) - 20);
		else if (vpick < 9)
			v = ($urandom_range(1) == 1) ? SENT_HIGH : SENT_LOW;
		else
			v = ($urandom_range(1) == 1) ? VAL_W'(HIGH_MARK + 1) : VAL_W'(LOW_MARK - 1);
		send_item(cmd, l, r, v);
	endtask

	task automatic run_phase(input int unsigned setting, input int unsigned send_pct,
			input int unsigned stall_pct, input int unsigned count, input bit squeeze);
		settle_block();
		write_span(POS_W'(setting));
		send_idle_pct = send_pct;
		rx_stall_pct  = stall_pct;
		if (squeeze)
			pressure_armed = 1'b1;
		for (int n = 0; n < count; n++)
			random_command((setting > LEAVES) ? LEAVES : setting);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// The node memory is swept to the sentinels before the input opens.
		do @(posedge clk); while (!in_ready);

		// An oversized setting is clipped to the full tree.
		write_span(POS_W'(POS_MAX));
		send_item(CMD_QUERY, 1, 1024, 0);
		send_item(CMD_QUERY, 0, 5, 0);
		send_item(CMD_QUERY, 6, 5, 0);
		send_item(CMD_QUERY, 1, 1025, 0);
		send_item(CMD_WRITE, 0, 0, 7);
		send_item(CMD_WRITE, 1025, 3, 7);
		send_item(CMD_WRITE, POS_MAX, POS_MAX, 7);
		// Values past either sentinel are saturated on write.
		send_item(CMD_WRITE, 1, 0, 31'sh3fffffff);
		send_item(CMD_QUERY, 1, 1, 31'sh3fffffff);
		send_item(CMD_WRITE, 1024, 0, 31'sh40000000);
		send_item(CMD_QUERY, 1, 1024, 0);
		send_item(CMD_WRITE, 1, 0, 5);
		send_item(CMD_QUERY, 1, 1024, 0);
		send_item(CMD_QUERY, 2, 1023, 0);
		send_item(CMD_WRITE, 512, 0, -3);
		send_item(CMD_WRITE, 513, 0, 9);
		send_item(CMD_QUERY, 512, 513, 0);
		send_item(CMD_QUERY, 513, 1024, 0);
		send_item(CMD_QUERY, 1, 512, 0);
		// A written sentinel value must not read back as empty.
		send_item(CMD_WRITE, 700, 0, SENT_LOW);
		send_item(CMD_QUERY, 700, 700, 0);
		send_item(CMD_WRITE, 701, 0, SENT_HIGH);
		send_item(CMD_QUERY, 700, 701, 0);
		send_item(CMD_QUERY, 1024, 1024, 0);

		run_phase(1024, 0, 0, 200, 1'b0);
		run_phase(16, 79, 0, 150, 1'b0);
		run_phase(1023, 0, 79, 200, 1'b0);
		run_phase(1, 27, 27, 80, 1'b0);
		run_phase(0, 0, 0, 40, 1'b0);
		run_phase(5, 0, 0, 120, 1'b1);
		run_phase(300, 27, 27, 200, 1'b0);
		run_phase(1024, 0, 79, 100, 1'b0);

		in_valid <= 1'b0;
		@(posedge clk);
		for (int wait_count = 0; tracker.outstanding() != 0 && wait_count < DRAIN_LIMIT;
				wait_count++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("%0d query results never arrived", tracker.outstanding());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0)
			$display("PASS range_min_max_segment_tree");
		else
			$display("FAIL range_min_max_segment_tree");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rmms_pkg.sv
sv/rmms_ctrl.sv
sv/rmms_datapath.sv
sv/range_min_max_segment_tree.sv
test/testbench.sv
